### rtl/assert_macros.svh
// assertion macros for the two-class fifo block
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

### rtl/tcfifo_pkg.sv
// shared types, constants and helpers for the two-class fifo block
// no dependencies
`timescale 1ns / 1ps
package tcfifo_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS     = 16;
   localparam int STAMP_BITS  = 16;

   // fixed widths of the request and response id fields
   localparam int FIELD_ID_BITS = 16;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_BITS = STAMP_BITS + ID_BITS;

   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   typedef enum logic [1:0] {
      KIND_DOG = 2'd0,
      KIND_CAT = 2'd1,
      KIND_ANY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } lane_ctl_type;

   typedef struct packed {
      logic [PTR_BITS-1:0] head;
      logic [PTR_BITS-1:0] tail;
      logic [CNT_BITS-1:0] count;
      logic                empty;
      logic                full;
   } lane_stat_type;

   // request id field to stored id
   function automatic logic [ID_BITS-1:0] id_to_store(input logic [FIELD_ID_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[ID_BITS-1:0];
   endfunction

   // stored id to response id field
   function automatic logic [FIELD_ID_BITS-1:0] id_to_field(input logic [ID_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[FIELD_ID_BITS-1:0];
   endfunction

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

endpackage

### rtl/two_class_fifo_oldest_first_top.sv
// top level of the two-class fifo with oldest-first dequeue
// depends on tcfifo_pkg, tcfifo_ram, tcfifo_lane and assert_macros.svh
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid req_stall req_mode req_kind   | in
//           | req_item_id                             |
//   result  | rsp_valid rsp_stall rsp_status          | out
//           | rsp_out_id rsp_out_kind                 |
//
// each word passes an accept step and an exec step: the accept step reads both
// queue heads from the entry memories into their read registers, the exec step
// decides, moves pointers, writes an enqueued entry and loads the result register
// reset clears pointers, counts and the stamp counter; the entry memories
// are not cleared, reads are guarded by the fill counts
// a stalled result waits in the output register while the next word is
// accepted; exec then holds until the output register frees up
`timescale 1ns / 1ps
`include "assert_macros.svh"
module two_class_fifo_oldest_first_top
   import tcfifo_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic [1:0]               req_kind,
   input  logic [FIELD_ID_BITS-1:0] req_item_id,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [FIELD_ID_BITS-1:0] rsp_out_id,
   output logic                     rsp_out_kind
);

   // engine state
   state_type state_ff, state_in;
   logic      accept;
   logic      rsp_free;
   logic      exec_done;

   // captured request
   logic               mode_ff;
   logic [1:0]         kind_ff;
   logic [ID_BITS-1:0] id_ff;

   // global arrival stamp
   logic [STAMP_BITS-1:0] arrival_ff, arrival_in;

   // lanes and memories
   lane_ctl_type  dog_ctl, cat_ctl;
   lane_stat_type dog_stat, cat_stat;
   logic [ENTRY_BITS-1:0] dog_rd, cat_rd;
   logic [ENTRY_BITS-1:0] wr_entry;

   // decision
   logic                  dog_push, cat_push, dog_pop, cat_pop;
   logic                  take_cat;
   logic                  kind_ok;
   status_type            dec_status;
   logic [STAMP_BITS-1:0] stamp_diff;
   logic [ID_BITS-1:0]    pick_id;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff;
   logic [FIELD_ID_BITS-1:0] rsp_out_id_ff;
   logic                     rsp_out_kind_ff;

   // ---------------------------------------------------------------- fsm
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      exec_done = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_EXEC: exec_done = rsp_free;
         default: req_stall = 1'b1;
      endcase
   end

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the request; payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         kind_ff <= req_kind;
         id_ff   <= id_to_store(req_item_id);
      end
   end

   // ---------------------------------------------------------------- storage
   tcfifo_lane u_dog_lane (
      .clock (clock),
      .reset (reset),
      .ctl   (dog_ctl),
      .stat  (dog_stat)
   );

   tcfifo_lane u_cat_lane (
      .clock (clock),
      .reset (reset),
      .ctl   (cat_ctl),
      .stat  (cat_stat)
   );

   // entry layout is {stamp, id}
   assign wr_entry = {arrival_ff, id_ff};

   // heads are read on accept; pointers only move in exec, so the read
   // never races the previous word's write
   tcfifo_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_dog_ram (
      .clock   (clock),
      .wr_en   (dog_ctl.push),
      .wr_addr (dog_stat.tail),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (dog_stat.head),
      .rd_data (dog_rd)
   );

   tcfifo_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_cat_ram (
      .clock   (clock),
      .wr_en   (cat_ctl.push),
      .wr_addr (cat_stat.tail),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (cat_stat.head),
      .rd_data (cat_rd)
   );

   // ---------------------------------------------------------------- decision
   // wrap-aware age: dog head is older or equal when cat minus dog stays
   // below half the stamp range
   assign stamp_diff = cat_rd[ENTRY_BITS-1:ID_BITS] - dog_rd[ENTRY_BITS-1:ID_BITS];

   always_comb begin
      dog_push   = 1'b0;
      cat_push   = 1'b0;
      dog_pop    = 1'b0;
      cat_pop    = 1'b0;
      take_cat   = 1'b0;
      kind_ok    = 1'b1;
      dec_status = STATUS_OK;
      if (mode_ff == MODE_ENQ) begin
         case (kind_ff)
            KIND_DOG: begin
               if (dog_stat.full) begin
                  dec_status = STATUS_FULL;
               end else begin
                  dog_push = 1'b1;
               end
            end
            KIND_CAT: begin
               if (cat_stat.full) begin
                  dec_status = STATUS_FULL;
               end else begin
                  cat_push = 1'b1;
               end
            end
            default: dec_status = STATUS_INVALID;
         endcase
      end else begin
         case (kind_ff)
            KIND_DOG: take_cat = 1'b0;
            KIND_CAT: take_cat = 1'b1;
            KIND_ANY: begin
               if (!dog_stat.empty && !cat_stat.empty) begin
                  take_cat = stamp_diff[STAMP_BITS-1];
               end else begin
                  take_cat = dog_stat.empty;
               end
            end
            default: kind_ok = 1'b0;
         endcase
         if (!kind_ok) begin
            dec_status = STATUS_INVALID;
         end else if (take_cat) begin
            if (cat_stat.empty) begin
               dec_status = STATUS_EMPTY;
            end else begin
               cat_pop = 1'b1;
            end
         end else begin
            if (dog_stat.empty) begin
               dec_status = STATUS_EMPTY;
            end else begin
               dog_pop = 1'b1;
            end
         end
      end
   end

   assign pick_id = cat_pop ? cat_rd[ID_BITS-1:0] : dog_rd[ID_BITS-1:0];

   // state only moves when the word retires into the result register
   assign dog_ctl.push = dog_push && exec_done;
   assign dog_ctl.pop  = dog_pop  && exec_done;
   assign cat_ctl.push = cat_push && exec_done;
   assign cat_ctl.pop  = cat_pop  && exec_done;

   // stamp advances only on a taken enqueue
   always_comb begin
      arrival_in = arrival_ff;
      if (dog_ctl.push || cat_ctl.push) begin
         arrival_in = arrival_ff + STAMP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arrival_ff <= '0;
      end else begin
         arrival_ff <= arrival_in;
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_done) begin
         rsp_status_ff   <= dec_status;
         rsp_out_id_ff   <= (dog_pop || cat_pop) ? id_to_field(pick_id) : '0;
         rsp_out_kind_ff <= cat_pop;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_out_id   = rsp_out_id_ff;
   assign rsp_out_kind = rsp_out_kind_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_CLK(a_accept_to_exec, clock, reset, accept |=> (state_ff == ST_EXEC))
   `ASSERT_CLK(a_done_gives_rsp, clock, reset, exec_done |=> rsp_valid_ff)
   `ASSERT_CLK(a_one_lane_op, clock, reset, $onehot0({dog_ctl, cat_ctl}))
   `ASSERT_NEVER(a_no_dog_push_full, clock, reset, dog_ctl.push && dog_stat.full)
   `ASSERT_NEVER(a_no_cat_push_full, clock, reset, cat_ctl.push && cat_stat.full)

endmodule

### rtl/tcfifo_ram.sv
// generic single-port-write, single-port-read synchronous ram
// read data registered; no dependencies
`timescale 1ns / 1ps
module tcfifo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tcfifo_lane.sv
// head, tail and fill count of one class queue
// depends on tcfifo_pkg
`timescale 1ns / 1ps
module tcfifo_lane
   import tcfifo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctl_type  ctl,
   output lane_stat_type stat
);

   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [PTR_BITS-1:0] tail_ff, tail_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.push) begin
         tail_in  = ptr_next(tail_ff);
         count_in = count_ff + CNT_BITS'(1);
      end else if (ctl.pop) begin
         head_in  = ptr_next(head_ff);
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign stat.head  = head_ff;
   assign stat.tail  = tail_ff;
   assign stat.count = count_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));

endmodule

### tb/two_class_fifo_oldest_first_top_tb.sv
// self-checking testbench for two_class_fifo_oldest_first_top
// depends on tcfifo_pkg and the rtl of the block; predicts every result word in-line
`timescale 1ns / 1ps
module two_class_fifo_oldest_first_top_tb
   import tcfifo_pkg::*;
();

   // kind code outside the enum, the block answers it with an invalid status
   localparam logic [1:0] KIND_RESERVED = 2'd3;
   // class field of a result word
   localparam logic CLASS_DOG = 1'b0;
   localparam logic CLASS_CAT = 1'b1;
   // generous bound: even a fully stalled run ends well inside it
   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int unsigned RANDOM_WORDS = 550;

   typedef struct packed {
      logic [STAMP_BITS-1:0] stamp;
      logic [ID_BITS-1:0]    id;
   } shelter_entry_type;

   typedef struct {
      status_type               status;
      logic [FIELD_ID_BITS-1:0] id;
      logic                     kind;
   } outcome_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_mode = MODE_ENQ;
   logic [1:0]               req_kind = KIND_DOG;
   logic [FIELD_ID_BITS-1:0] req_item_id = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic [FIELD_ID_BITS-1:0] rsp_out_id;
   logic                     rsp_out_kind;

   // predictor state: one queue per class plus the arrival stamp counter
   shelter_entry_type     dog_lane[$];
   shelter_entry_type     cat_lane[$];
   logic [STAMP_BITS-1:0] next_stamp = '0;

   // result words still owed by the block, oldest first
   outcome_type pending_outcomes[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned sink_wait = 0;
   bit          src_pace = 1'b1;
   bit          sink_pace = 1'b1;

   two_class_fifo_oldest_first_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_kind    (req_kind),
      .req_item_id (req_item_id),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_out_id  (rsp_out_id),
      .rsp_out_kind(rsp_out_kind)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("two_class_fifo_oldest_first_top_tb NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // next result of the block for one accepted request, updates the shadow queues
   function automatic outcome_type shelter_predict(input logic mode, input logic [1:0] kind,
                                                   input logic [FIELD_ID_BITS-1:0] id);
      outcome_type           res;
      shelter_entry_type     ent;
      logic [1:0]            pick;
      logic [STAMP_BITS-1:0] age_gap;
      res.status = STATUS_OK;
      res.id = '0;
      res.kind = CLASS_DOG;
      if (mode == MODE_ENQ) begin
         if (kind == KIND_DOG || kind == KIND_CAT) begin
            if ((kind == KIND_DOG ? dog_lane.size() : cat_lane.size()) >= QUEUE_DEPTH) begin
               // full queue: word dropped, stamp counter holds
               res.status = STATUS_FULL;
            end else begin
               ent.stamp = next_stamp;
               ent.id = ID_BITS'(id);
               if (kind == KIND_DOG)
                  dog_lane.push_back(ent);
               else
                  cat_lane.push_back(ent);
               next_stamp = next_stamp + STAMP_BITS'(1);
            end
         end else begin
            res.status = STATUS_INVALID;
         end
      end else begin
         pick = kind;
         if (kind == KIND_ANY) begin
            if (dog_lane.size() != 0 && cat_lane.size() != 0) begin
               // wrap-aware age: dog wins ties and any cat head less than half a wrap newer
               age_gap = cat_lane[0].stamp - dog_lane[0].stamp;
               pick = age_gap[STAMP_BITS-1] ? KIND_CAT : KIND_DOG;
            end else begin
               pick = (dog_lane.size() == 0) ? KIND_CAT : KIND_DOG;
            end
         end
         if (pick == KIND_DOG) begin
            if (dog_lane.size() == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               ent = dog_lane.pop_front();
               res.id = FIELD_ID_BITS'(ent.id);
               res.kind = CLASS_DOG;
            end
         end else if (pick == KIND_CAT) begin
            if (cat_lane.size() == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               ent = cat_lane.pop_front();
               res.id = FIELD_ID_BITS'(ent.id);
               res.kind = CLASS_CAT;
            end
         end else begin
            res.status = STATUS_INVALID;
         end
      end
      return res;
   endfunction

   // result side: compare each accepted word, then draw the stall for the next one
   always @(posedge clock) begin : result_check
      outcome_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch($sformatf("unexpected result word status=%0d id=%h kind=%0d",
                                         rsp_status, rsp_out_id, rsp_out_kind));
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
               if (rsp_out_id !== want.id)
                  report_mismatch($sformatf("out_id %h, want %h", rsp_out_id, want.id));
               if (rsp_out_kind !== want.kind)
                  report_mismatch($sformatf("out_kind %0d, want %0d", rsp_out_kind, want.kind));
            end
            sink_wait = sink_pace ? $urandom_range(11, 0) : 0;
         end
         // stall may also be up before the next word shows, valid never looks at it
         if (sink_wait != 0) begin
            rsp_stall <= 1'b1;
            sink_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one request word, hold it until taken, then log its expected result
   task automatic send_word(input logic mode, input logic [1:0] kind,
                            input logic [FIELD_ID_BITS-1:0] id);
      int unsigned gap;
      gap = src_pace ? $urandom_range(11, 0) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_kind    <= kind;
      req_item_id <= id;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(shelter_predict(mode, kind, id));
   endtask

   // sender goes quiet until the block has answered everything
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [FIELD_ID_BITS-1:0] pick_id();
      int unsigned sel;
      sel = $urandom_range(7, 0);
      // lean on the all-zero and all-one ids now and then
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return FIELD_ID_BITS'($urandom_range(65535, 0));
   endfunction

   // empty queues, invalid kinds, enqueue to any
   task automatic test_empty_and_invalid();
      send_word(MODE_DEQ, KIND_DOG, 16'hFFFF);
      send_word(MODE_DEQ, KIND_CAT, 16'h0000);
      send_word(MODE_DEQ, KIND_ANY, 16'hFFFF);
      send_word(MODE_ENQ, KIND_ANY, 16'hFFFF);
      send_word(MODE_ENQ, KIND_RESERVED, 16'h1234);
      send_word(MODE_DEQ, KIND_RESERVED, 16'h0000);
   endtask

   // oldest-first choice with both heads present, then with one side empty
   task automatic test_oldest_first();
      send_word(MODE_ENQ, KIND_DOG, 16'hFFFF);
      send_word(MODE_ENQ, KIND_CAT, 16'h0000);
      send_word(MODE_ENQ, KIND_CAT, 16'hA5A5);
      send_word(MODE_DEQ, KIND_ANY, 16'h0000);
      send_word(MODE_DEQ, KIND_ANY, 16'h0000);
      // dog side refilled, the last cat head goes by an explicit cat dequeue
      send_word(MODE_ENQ, KIND_DOG, 16'h5A5A);
      send_word(MODE_DEQ, KIND_CAT, 16'h0000);
      // cat side empty, any takes the dog head
      send_word(MODE_DEQ, KIND_ANY, 16'hFFFF);
      send_word(MODE_DEQ, KIND_DOG, 16'h0000);
   endtask

   // fill the cat queue, push one past full, then drain it
   task automatic test_full_queue();
      repeat (QUEUE_DEPTH + 1) send_word(MODE_ENQ, KIND_CAT, pick_id());
      send_word(MODE_ENQ, KIND_DOG, pick_id());
      // hold off until the block is fully caught up
      wait_drained();
      send_word(MODE_DEQ, KIND_ANY, 16'h0000);
      repeat (QUEUE_DEPTH) send_word(MODE_DEQ, KIND_ANY, pick_id());
   endtask

   // cats older than a full dog queue, newer cats behind it, then drain by age
   task automatic test_interleaved_heads();
      while (dog_lane.size() + cat_lane.size() != 0) send_word(MODE_DEQ, KIND_ANY, '0);
      wait_drained();
      repeat (4) send_word(MODE_ENQ, KIND_CAT, pick_id());
      repeat (QUEUE_DEPTH) send_word(MODE_ENQ, KIND_DOG, pick_id());
      repeat (4) send_word(MODE_ENQ, KIND_CAT, pick_id());
      repeat (2 * QUEUE_DEPTH) send_word(MODE_DEQ, KIND_ANY, pick_id());
   endtask

   // one random word: mostly well-formed traffic, some invalid noise
   task automatic random_word(input int unsigned enq_pct);
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 8) begin
         if ($urandom_range(1, 0) != 0)
            send_word(MODE_ENQ, KIND_ANY, pick_id());
         else
            send_word(logic'($urandom_range(1, 0)), KIND_RESERVED, pick_id());
      end else if ($urandom_range(99, 0) < enq_pct) begin
         send_word(MODE_ENQ, $urandom_range(1, 0) != 0 ? KIND_CAT : KIND_DOG, pick_id());
      end else begin
         case ($urandom_range(2, 0))
            0: begin
               send_word(MODE_DEQ, KIND_DOG, pick_id());
            end
            1: begin
               send_word(MODE_DEQ, KIND_CAT, pick_id());
            end
            default: begin
               send_word(MODE_DEQ, KIND_ANY, pick_id());
            end
         endcase
      end
   endtask

   // segments of random traffic, each with its own fill bias and pacing
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned seg_len;
      int unsigned enq_pct;
      int unsigned seg_idx;
      sent = 0;
      seg_idx = 0;
      while (sent < RANDOM_WORDS) begin
         seg_len = $urandom_range(60, 20);
         case ($urandom_range(2, 0))
            0: begin
               enq_pct = 25;
            end
            1: begin
               enq_pct = 50;
            end
            default: begin
               enq_pct = 80;
            end
         endcase
         // some segments run flat out on one or both sides
         src_pace = $urandom_range(3, 0) != 0;
         sink_pace = $urandom_range(3, 0) != 0;
         repeat (seg_len) random_word(enq_pct);
         sent += seg_len;
         seg_idx++;
         if (seg_idx % 3 == 0)
            wait_drained();
      end
      src_pace = 1'b1;
      sink_pace = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_invalid();
      test_oldest_first();
      test_full_queue();
      test_interleaved_heads();
      test_random_traffic();
      wait_drained();
      // let any late or spurious word show up before the verdict
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("two_class_fifo_oldest_first_top_tb OK");
      else
         $display("two_class_fifo_oldest_first_top_tb NOT OK");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/tcfifo_pkg.sv
rtl/tcfifo_ram.sv
rtl/tcfifo_lane.sv
rtl/two_class_fifo_oldest_first_top.sv
tb/two_class_fifo_oldest_first_top_tb.sv
